// ----- hdl/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the supply loss monitor.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int SampleWidth    = 10;
   localparam int IntegWidth     = 16;
   localparam int CountWidth     = 32;
   localparam int IntervalWidth  = 16;
   localparam int LimitWidth     = 22;   // 60 * 65535 fits in 22 bits
   localparam int DaysWidth      = 16;
   localparam int HoursWidth     = 5;
   localparam int MinutesWidth   = 6;
   localparam int SecondsWidth   = 6;

   // filter time constant: integrator scales the level by 2^FilterShift
   localparam int FilterShift    = 4;

   localparam logic [SampleWidth-1:0]  ThresholdReset = 10'd248;
   localparam logic [SampleWidth-1:0]  LevelMax       = 10'h3ff;
   localparam logic [SecondsWidth-1:0] SecondsLast    = 6'd59;
   localparam logic [MinutesWidth-1:0] MinutesLast    = 6'd59;
   localparam logic [HoursWidth-1:0]   HoursLast      = 5'd23;

   // csr decode uses address bit 2 (registers at byte 0 and 4)
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   typedef enum logic {
      REG_INTERVAL  = 1'b0,
      REG_THRESHOLD = 1'b1
   } reg_idx_type;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_REPORT = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      logic clear;
      logic count_up;
   } timer_ctrl_type;

   typedef struct packed {
      logic [CountWidth-1:0]   count;
      logic [DaysWidth-1:0]    days;
      logic [HoursWidth-1:0]   hours;
      logic [MinutesWidth-1:0] minutes;
      logic [SecondsWidth-1:0] seconds;
   } timer_stat_type;

endpackage

// ----- hdl/slm_outage_timer.sv -----
// ----------------------------------------------------------------------------
// slm_outage_timer
// Saturating outage second counter kept alongside a days/hours/minutes/
// seconds split, so a report needs no division.
// ----------------------------------------------------------------------------
module slm_outage_timer
   import slm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  timer_ctrl_type ctrl,
   output timer_stat_type stat
);

   logic [CountWidth-1:0]   count_ff,   count_in;
   logic [DaysWidth-1:0]    days_ff,    days_in;
   logic [HoursWidth-1:0]   hours_ff,   hours_in;
   logic [MinutesWidth-1:0] minutes_ff, minutes_in;
   logic [SecondsWidth-1:0] seconds_ff, seconds_in;

   always_comb begin
      count_in   = count_ff;
      days_in    = days_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      if (ctrl.clear) begin
         count_in   = '0;
         days_in    = '0;
         hours_in   = '0;
         minutes_in = '0;
         seconds_in = '0;
      end else if (ctrl.count_up && (count_ff != '1)) begin
         count_in = count_ff + CountWidth'(1);
         if (seconds_ff != SecondsLast) begin
            seconds_in = seconds_ff + SecondsWidth'(1);
         end else begin
            seconds_in = '0;
            if (minutes_ff != MinutesLast) begin
               minutes_in = minutes_ff + MinutesWidth'(1);
            end else begin
               minutes_in = '0;
               if (hours_ff != HoursLast) begin
                  hours_in = hours_ff + HoursWidth'(1);
               end else begin
                  hours_in = '0;
                  days_in  = days_ff + DaysWidth'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         days_ff    <= '0;
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
      end else begin
         count_ff   <= count_in;
         days_ff    <= days_in;
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
      end
   end

   assign stat.count   = count_ff;
   assign stat.days    = days_ff;
   assign stat.hours   = hours_ff;
   assign stat.minutes = minutes_ff;
   assign stat.seconds = seconds_ff;

endmodule

// ----- hdl/supply_loss_monitor.sv -----
// ----------------------------------------------------------------------------
// supply_loss_monitor
// Supply level filter, outage second counter and one-shot outage report.
// ----------------------------------------------------------------------------
// Each transaction is captured in an input register, processed combinationally
// against the monitor state and held in the result register until taken; one
// result comes out per transaction, in order. One transaction per clock is
// accepted unless both registers are full and the result is not taken. The
// outage time is a saturating second count plus a running days/hours/minutes/
// seconds split, so a report is formed without any division. Registers: 0x0
// report interval in minutes (zero disables reporting), 0x4 power threshold.
// ----------------------------------------------------------------------------
module supply_loss_monitor
   import slm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [1:0] operation, [11:2] sample, [15:12] zero
   input  logic [15:0]             req_tdata,

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [9:0] filtered_level, [10] power_present, [11] report_fire,
   // [27:12] outage_days, [32:28] outage_hours, [38:33] outage_minutes,
   // [44:39] outage_seconds, [47:45] zero
   output logic [47:0]             rsp_tdata,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   // configuration
   logic [IntervalWidth-1:0] interval_ff;
   logic [SampleWidth-1:0]   threshold_ff;
   logic                     csr_write;
   reg_idx_type              csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= '0;
         threshold_ff <= ThresholdReset;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_INTERVAL:  interval_ff  <= csr_pwdata[IntervalWidth-1:0];
            REG_THRESHOLD: threshold_ff <= csr_pwdata[SampleWidth-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INTERVAL:  csr_prdata = {{(CsrDataWidth-IntervalWidth){1'b0}}, interval_ff};
         REG_THRESHOLD: csr_prdata = {{(CsrDataWidth-SampleWidth){1'b0}}, threshold_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic                   in_valid_ff;
   op_type                 op_ff;
   logic [SampleWidth-1:0] sample_ff;
   logic                   rsp_valid_ff;
   logic                   out_free;
   logic                   in_free;
   logic                   step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign in_free    = !in_valid_ff || out_free;
   assign req_tready = in_free;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && in_free) begin
         op_ff     <= op_type'(req_tdata[1:0]);
         sample_ff <= req_tdata[11:2];
      end
   end

   // monitor state
   logic [IntegWidth-1:0]  integ_ff,    integ_in;
   logic [SampleWidth-1:0] filtered_ff, filtered_in;
   logic                   done_ff,     done_in;
   logic [IntegWidth-1:0]  integ_shift;
   logic [SampleWidth-1:0] filt_sat;
   logic [LimitWidth-1:0]  limit;
   logic                   above_now;
   logic                   below_limit;
   logic                   fire;
   timer_ctrl_type         timer_ctrl;
   timer_stat_type         timer_stat;

   assign integ_shift = integ_ff >> FilterShift;
   assign filt_sat    = (integ_shift > IntegWidth'(LevelMax)) ? LevelMax
                                                              : integ_shift[SampleWidth-1:0];
   assign above_now   = filtered_ff > threshold_ff;
   // interval * 60 as 64x - 4x
   assign limit       = {interval_ff, 6'b0} - {4'b0, interval_ff, 2'b0};
   assign below_limit = timer_stat.count < {{(CountWidth-LimitWidth){1'b0}}, limit};

   always_comb begin
      integ_in            = integ_ff;
      filtered_in         = filtered_ff;
      done_in             = done_ff;
      fire                = 1'b0;
      timer_ctrl.clear    = 1'b0;
      timer_ctrl.count_up = 1'b0;
      unique case (op_ff)
         OP_SAMPLE: begin
            filtered_in = filt_sat;
            integ_in    = integ_ff - IntegWidth'(filt_sat) + IntegWidth'(sample_ff);
         end
         OP_TICK: begin
            timer_ctrl.clear    = above_now;
            timer_ctrl.count_up = !above_now;
         end
         OP_REPORT: begin
            if (interval_ff != '0) begin
               if (below_limit) begin
                  done_in = 1'b0;
               end else if (!done_ff) begin
                  fire    = 1'b1;
                  done_in = 1'b1;
               end
            end
         end
         OP_NOP: ;
         default: ;
      endcase
      if (!step) begin
         timer_ctrl.clear    = 1'b0;
         timer_ctrl.count_up = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         filtered_ff <= '0;
         done_ff     <= 1'b1;
      end else if (step) begin
         integ_ff    <= integ_in;
         filtered_ff <= filtered_in;
         done_ff     <= done_in;
      end
   end

   slm_outage_timer u_timer (
      .clock (clock),
      .reset (reset),
      .ctrl  (timer_ctrl),
      .stat  (timer_stat)
   );

   // result register
   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {3'b0,
                         fire ? timer_stat.seconds : {SecondsWidth{1'b0}},
                         fire ? timer_stat.minutes : {MinutesWidth{1'b0}},
                         fire ? timer_stat.hours   : {HoursWidth{1'b0}},
                         fire ? timer_stat.days    : {DaysWidth{1'b0}},
                         fire,
                         filtered_in > threshold_ff,
                         filtered_in};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
